// ----- rtl/assert_macros.svh -----
// Assertion macros used by the receiver unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ufr_wd_pkg.sv -----
// Shared types and constants for the UART frame receiver with link watchdog.
`timescale 1ns / 1ps

package ufr_wd_pkg;

   localparam int FRAME_LEN_DEFAULT = 7;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_MS    = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

   typedef enum logic [2:0] {
      PHASE_HEAD1 = 3'b001,
      PHASE_HEAD2 = 3'b010,
      PHASE_BODY  = 3'b100
   } phase_type;

endpackage

// ----- rtl/uart_frame_receiver_with_link_watchdog_unit.sv -----
// Top level: header hunt, frame checksum check and link watchdog.
// Each response is registered and shows in the cycle after its request is accepted.
// Throughput: one request per cycle while the response register is empty or rsp_ready is high.
// All frame and watchdog state updates on request acceptance, in the same cycle as the response register.
// Reset clears hunt state, counters, online flag and CSRs (timeout 1000 ms).
// The four frame body bytes are not cleared by reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uart_frame_receiver_with_link_watchdog_unit #(
   parameter int FRAME_LEN = ufr_wd_pkg::FRAME_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_frame_ready,
   output logic [7:0]                        rsp_command_code,
   output logic [7:0]                        rsp_payload_first,
   output logic [7:0]                        rsp_payload_second,
   output logic [7:0]                        rsp_payload_third,
   output logic                              rsp_checksum_bad,
   output logic                              rsp_link_online,
   output logic                              rsp_went_offline,
   output logic [31:0]                       rsp_good_frame_total,
   output logic [31:0]                       rsp_bad_checksum_total,
   output logic [31:0]                       rsp_offline_total,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ufr_wd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ufr_wd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ufr_wd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);

   import ufr_wd_pkg::*;

   localparam int POS_BITS = $clog2(FRAME_LEN - 2);
   localparam int POS_W    = (POS_BITS < 3) ? 3 : POS_BITS;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 3);

   logic [7:0]       header_first_ff;
   logic [7:0]       header_second_ff;
   logic [15:0]      timeout_ff;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       body_ff [4];
   logic             body_we;
   logic             online_ff, online_in;
   logic [15:0]      idle_ff, idle_in, idle_inc;
   logic [31:0]      good_count_ff, good_count_in;
   logic [31:0]      bad_count_ff, bad_count_in;
   logic [31:0]      timeout_count_ff, timeout_count_in;

   logic             ready_in, bad_in, dropped_in;

   logic             rsp_valid_ff;
   logic             rsp_frame_ready_ff;
   logic [7:0]       rsp_body_ff [4];
   logic             rsp_checksum_bad_ff;
   logic             rsp_link_online_ff;
   logic             rsp_went_offline_ff;
   logic [31:0]      rsp_good_ff;
   logic [31:0]      rsp_bad_ff;
   logic [31:0]      rsp_offline_ff;

   logic             req_accept;
   logic             csr_write;
   logic [1:0]       csr_index;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      case (csr_index)
         CSR_HEADER_FIRST:  prdata = {{(CSR_DATA_W - 8){1'b0}}, header_first_ff};
         CSR_HEADER_SECOND: prdata = {{(CSR_DATA_W - 8){1'b0}}, header_second_ff};
         CSR_TIMEOUT_MS:    prdata = {{(CSR_DATA_W - 16){1'b0}}, timeout_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= 8'd0;
         header_second_ff <= 8'd0;
         timeout_ff       <= TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HEADER_FIRST:  header_first_ff  <= pwdata[7:0];
            CSR_HEADER_SECOND: header_second_ff <= pwdata[7:0];
            CSR_TIMEOUT_MS:    timeout_ff       <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign idle_inc = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;

   always_comb begin
      phase_in         = phase_ff;
      pos_in           = pos_ff;
      sum_in           = sum_ff;
      body_we          = 1'b0;
      online_in        = online_ff;
      idle_in          = idle_ff;
      good_count_in    = good_count_ff;
      bad_count_in     = bad_count_ff;
      timeout_count_in = timeout_count_ff;
      ready_in         = 1'b0;
      bad_in           = 1'b0;
      dropped_in       = 1'b0;
      if (req_type) begin
         idle_in = idle_inc;
         if (online_ff && (idle_inc > timeout_ff)) begin
            online_in        = 1'b0;
            timeout_count_in = timeout_count_ff + 32'd1;
            dropped_in       = 1'b1;
         end
      end else begin
         case (phase_ff)
            PHASE_HEAD1: begin
               if (req_rx_byte == header_first_ff) begin
                  sum_in   = req_rx_byte;
                  phase_in = PHASE_HEAD2;
               end
            end
            PHASE_HEAD2: begin
               if (req_rx_byte == header_second_ff) begin
                  sum_in   = sum_ff + req_rx_byte;
                  pos_in   = '0;
                  phase_in = PHASE_BODY;
               end else if (req_rx_byte == header_first_ff) begin
                  sum_in = req_rx_byte;
               end else begin
                  pos_in   = '0;
                  phase_in = PHASE_HEAD1;
               end
            end
            PHASE_BODY: begin
               if (pos_ff == LAST_POS) begin
                  if (req_rx_byte == sum_ff) begin
                     ready_in      = 1'b1;
                     online_in     = 1'b1;
                     idle_in       = 16'd0;
                     good_count_in = good_count_ff + 32'd1;
                  end else begin
                     bad_in       = 1'b1;
                     bad_count_in = bad_count_ff + 32'd1;
                  end
                  pos_in   = '0;
                  phase_in = PHASE_HEAD1;
               end else begin
                  body_we = (pos_ff < POS_W'(4));
                  sum_in  = sum_ff + req_rx_byte;
                  pos_in  = pos_ff + POS_W'(1);
               end
            end
            default: begin
               pos_in   = '0;
               phase_in = PHASE_HEAD1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_HEAD1;
         pos_ff           <= '0;
         sum_ff           <= 8'd0;
         online_ff        <= 1'b0;
         idle_ff          <= 16'd0;
         good_count_ff    <= 32'd0;
         bad_count_ff     <= 32'd0;
         timeout_count_ff <= 32'd0;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         online_ff        <= online_in;
         idle_ff          <= idle_in;
         good_count_ff    <= good_count_in;
         bad_count_ff     <= bad_count_in;
         timeout_count_ff <= timeout_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && body_we) begin
         body_ff[pos_ff[1:0]] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_frame_ready_ff  <= ready_in;
         rsp_checksum_bad_ff <= bad_in;
         rsp_link_online_ff  <= online_in;
         rsp_went_offline_ff <= dropped_in;
         rsp_good_ff         <= good_count_in;
         rsp_bad_ff          <= bad_count_in;
         rsp_offline_ff      <= timeout_count_in;
         for (int i = 0; i < 4; i++) begin
            rsp_body_ff[i] <= ready_in ? body_ff[i] : 8'd0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frame_ready        = rsp_frame_ready_ff;
   assign rsp_command_code       = rsp_body_ff[0];
   assign rsp_payload_first      = rsp_body_ff[1];
   assign rsp_payload_second     = rsp_body_ff[2];
   assign rsp_payload_third      = rsp_body_ff[3];
   assign rsp_checksum_bad       = rsp_checksum_bad_ff;
   assign rsp_link_online        = rsp_link_online_ff;
   assign rsp_went_offline       = rsp_went_offline_ff;
   assign rsp_good_frame_total   = rsp_good_ff;
   assign rsp_bad_checksum_total = rsp_bad_ff;
   assign rsp_offline_total      = rsp_offline_ff;

   `ASSERT_RST(a_good_frame_online, clock, reset, rsp_valid_ff && rsp_frame_ready_ff |-> rsp_link_online_ff, "good frame response without link online")
   `ASSERT_RST(a_offline_alone, clock, reset, rsp_valid_ff && rsp_went_offline_ff |-> !rsp_link_online_ff && !rsp_frame_ready_ff && !rsp_checksum_bad_ff, "offline response with online flag or frame status")
   `ASSERT_RST(a_good_count_step, clock, reset, req_accept |=> good_count_ff == $past(good_count_ff) + 32'(rsp_frame_ready_ff), "good frame count out of step with frame status")

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the UART frame receiver with link watchdog.
`timescale 1ns / 1ps

module tb_top;
   import ufr_wd_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int BODY_BYTES    = FRAME_LEN_DEFAULT - 3;

   typedef struct packed {
      logic       is_tick;
      logic [7:0] rx_byte;
   } uart_req_type;

   typedef struct packed {
      logic        frame_ready;
      logic [7:0]  command_code;
      logic [7:0]  payload_first;
      logic [7:0]  payload_second;
      logic [7:0]  payload_third;
      logic        checksum_bad;
      logic        link_online;
      logic        went_offline;
      logic [31:0] good_total;
      logic [31:0] bad_total;
      logic [31:0] offline_total;
   } link_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_frame_ready;
   logic [7:0]  rsp_command_code;
   logic [7:0]  rsp_payload_first;
   logic [7:0]  rsp_payload_second;
   logic [7:0]  rsp_payload_third;
   logic        rsp_checksum_bad;
   logic        rsp_link_online;
   logic        rsp_went_offline;
   logic [31:0] rsp_good_frame_total;
   logic [31:0] rsp_bad_checksum_total;
   logic [31:0] rsp_offline_total;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   // predictor copy of the registers and the receiver state
   logic [7:0]  cfg_head1 = 8'h00;
   logic [7:0]  cfg_head2 = 8'h00;
   logic [15:0] cfg_timeout = TIMEOUT_RESET;
   phase_type   hunt_state = PHASE_HEAD1;
   logic [2:0]  body_pos = '0;
   logic [7:0]  body_mem [4];
   logic [7:0]  run_sum = '0;
   logic        online = 1'b0;
   logic [15:0] idle_ms = '0;
   logic [31:0] good_cnt = '0;
   logic [31:0] bad_cnt = '0;
   logic [31:0] offline_cnt = '0;

   uart_req_type    pending_q[$];
   link_result_type link_result_q[$];
   uart_req_type    drv_item;
   link_result_type drv_want;
   link_result_type mon_got;
   link_result_type mon_want;

   int requests_queued = 0;
   int responses_seen = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 27;
   int recv_idle_pct = 78;
   bit hold_off_armed = 1'b0;
   int hold_off_left = HOLD_OFF_LEN;

   uart_frame_receiver_with_link_watchdog_unit #(
      .FRAME_LEN(FRAME_LEN_DEFAULT)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_frame_ready       (rsp_frame_ready),
      .rsp_command_code      (rsp_command_code),
      .rsp_payload_first     (rsp_payload_first),
      .rsp_payload_second    (rsp_payload_second),
      .rsp_payload_third     (rsp_payload_third),
      .rsp_checksum_bad      (rsp_checksum_bad),
      .rsp_link_online       (rsp_link_online),
      .rsp_went_offline      (rsp_went_offline),
      .rsp_good_frame_total  (rsp_good_frame_total),
      .rsp_bad_checksum_total(rsp_bad_checksum_total),
      .rsp_offline_total     (rsp_offline_total),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void frame_link_predict(input uart_req_type it,
                                              output link_result_type res);
      logic [7:0] b;
      b = it.rx_byte;
      res = '0;
      if (it.is_tick) begin
         if (idle_ms != IDLE_MAX) begin
            idle_ms = idle_ms + 16'd1;
         end
         if (online && idle_ms > cfg_timeout) begin
            online = 1'b0;
            offline_cnt = offline_cnt + 32'd1;
            res.went_offline = 1'b1;
         end
      end else begin
         case (hunt_state)
            PHASE_HEAD1: begin
               if (b == cfg_head1) begin
                  run_sum = b;
                  hunt_state = PHASE_HEAD2;
               end
            end
            PHASE_HEAD2: begin
               if (b == cfg_head2) begin
                  run_sum = run_sum + b;
                  body_pos = '0;
                  hunt_state = PHASE_BODY;
               end else if (b == cfg_head1) begin
                  run_sum = b;
               end else begin
                  body_pos = '0;
                  hunt_state = PHASE_HEAD1;
               end
            end
            PHASE_BODY: begin
               if (int'(body_pos) + 3 >= FRAME_LEN_DEFAULT) begin
                  if (b == run_sum) begin
                     res.frame_ready = 1'b1;
                     online = 1'b1;
                     idle_ms = '0;
                     good_cnt = good_cnt + 32'd1;
                     res.command_code = body_mem[0];
                     res.payload_first = body_mem[1];
                     res.payload_second = body_mem[2];
                     res.payload_third = body_mem[3];
                  end else begin
                     res.checksum_bad = 1'b1;
                     bad_cnt = bad_cnt + 32'd1;
                  end
                  body_pos = '0;
                  hunt_state = PHASE_HEAD1;
               end else begin
                  if (body_pos < 3'd4) begin
                     body_mem[body_pos[1:0]] = b;
                  end
                  run_sum = run_sum + b;
                  body_pos = body_pos + 3'd1;
               end
            end
            default: begin
               body_pos = '0;
               hunt_state = PHASE_HEAD1;
            end
         endcase
      end
      res.link_online = online;
      res.good_total = good_cnt;
      res.bad_total = bad_cnt;
      res.offline_total = offline_cnt;
   endfunction

   // driver: offer queued requests, predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            frame_link_predict(drv_item, drv_want);
            link_result_q.push_back(drv_want);
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_item = pending_q.pop_front();
               req_valid <= 1'b1;
               req_type <= drv_item.is_tick;
               req_rx_byte <= drv_item.rx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input link_result_type want,
                                  input link_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("tb_top: %s at response %0d", what, responses_seen);
         $display("exp rdy=%0b cmd=%02h pl=%02h %02h %02h bad=%0b on=%0b off=%0b",
                  want.frame_ready, want.command_code, want.payload_first,
                  want.payload_second, want.payload_third, want.checksum_bad,
                  want.link_online, want.went_offline);
         $display("    cnt=%0d/%0d/%0d", want.good_total, want.bad_total,
                  want.offline_total);
         $display("got rdy=%0b cmd=%02h pl=%02h %02h %02h bad=%0b on=%0b off=%0b",
                  got.frame_ready, got.command_code, got.payload_first,
                  got.payload_second, got.payload_third, got.checksum_bad,
                  got.link_online, got.went_offline);
         $display("    cnt=%0d/%0d/%0d", got.good_total, got.bad_total,
                  got.offline_total);
      end
   endtask

   // monitor: accept responses, compare against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            mon_got = {rsp_frame_ready, rsp_command_code, rsp_payload_first,
                       rsp_payload_second, rsp_payload_third, rsp_checksum_bad,
                       rsp_link_online, rsp_went_offline, rsp_good_frame_total,
                       rsp_bad_checksum_total, rsp_offline_total};
            if (link_result_q.size() == 0) begin
               report_mismatch("unexpected response", '0, mon_got);
            end else begin
               mon_want = link_result_q.pop_front();
               if (mon_got !== mon_want) begin
                  report_mismatch("mismatch", mon_want, mon_got);
               end
            end
         end
         if (hold_off_armed && hold_off_left != 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic push_req(input logic is_tick, input logic [7:0] b);
      pending_q.push_back('{is_tick: is_tick, rx_byte: b});
      requests_queued++;
   endtask

   task automatic push_frame(input logic [7:0] cmd, input logic [7:0] p1,
                             input logic [7:0] p2, input logic [7:0] p3,
                             input bit corrupt, input bit repeat_head);
      logic [7:0] sum;
      sum = cfg_head1 + cfg_head2 + cmd + p1 + p2 + p3;
      if (corrupt) begin
         sum = sum + 8'($urandom_range(1, 255));
      end
      push_req(1'b0, cfg_head1);
      if (repeat_head) begin
         push_req(1'b0, cfg_head1);
      end
      push_req(1'b0, cfg_head2);
      push_req(1'b0, cmd);
      push_req(1'b0, p1);
      push_req(1'b0, p2);
      push_req(1'b0, p3);
      push_req(1'b0, sum);
   endtask

   task automatic push_random_traffic(input int n);
      int stop_at;
      int r;
      int burst_max;
      stop_at = requests_queued + n;
      burst_max = (cfg_timeout > 16'd30) ? 6 : int'(cfg_timeout) + 3;
      while (requests_queued < stop_at) begin
         r = $urandom_range(99);
         if (r < 50) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                       $urandom_range(99) < 20);
         end else if (r < 62) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1,
                       $urandom_range(99) < 20);
         end else if (r < 72) begin
            push_req(1'b0, cfg_head1);
            repeat ($urandom_range(0, BODY_BYTES + 1)) push_req(1'b0, 8'($urandom));
         end else if (r < 87) begin
            repeat ($urandom_range(1, burst_max)) push_req(1'b1, 8'($urandom));
         end else begin
            push_req(1'($urandom_range(1)), 8'($urandom));
         end
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_HEADER_FIRST:  cfg_head1 = val[7:0];
         CSR_HEADER_SECOND: cfg_head2 = val[7:0];
         CSR_TIMEOUT_MS:    cfg_timeout = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_link_config(input logic [7:0] h1, input logic [7:0] h2,
                                  input logic [15:0] tmo);
      csr_write(CSR_HEADER_FIRST, {24'd0, h1});
      csr_write(CSR_HEADER_SECOND, {24'd0, h2});
      csr_write(CSR_TIMEOUT_MS, {16'd0, tmo});
   endtask

   task automatic drain_responses();
      while (responses_seen < requests_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (reset) @(posedge clock);

      // equal headers out of reset: second-header match takes priority
      push_frame(8'h01, 8'h02, 8'h03, 8'h04, 1'b0, 1'b0);
      drain_responses();

      set_link_config(8'hAA, 8'h55, 16'd2);
      push_req(1'b1, 8'hFF);
      push_frame(8'hFF, 8'h00, 8'h80, 8'h7F, 1'b0, 1'b1);
      repeat (3) push_req(1'b1, 8'h00);
      push_req(1'b0, 8'hAA);
      push_req(1'b0, 8'h13);
      push_frame(8'h01, 8'h02, 8'h03, 8'h04, 1'b1, 1'b0);
      drain_responses();

      set_link_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 20)));
      push_random_traffic(650);
      drain_responses();

      send_idle_pct = 78;
      recv_idle_pct = 27;
      set_link_config(8'hFF, 8'hFF, 16'd0);
      push_random_traffic(650);
      drain_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_link_config(8'h00, 8'hFF, 16'd1);
      hold_off_armed = 1'b1;
      push_random_traffic(650);
      drain_responses();

      repeat (8) @(posedge clock);
      mismatch_count += link_result_q.size();
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ufr_wd_pkg.sv
rtl/uart_frame_receiver_with_link_watchdog_unit.sv
verif/tb_top.sv
